/* sv/delayed_linear_resampler_top_defines.svh */
// Assertion macros used by the resampler top.
`ifndef DELAYED_LINEAR_RESAMPLER_TOP_DEFINES_SVH
`define DELAYED_LINEAR_RESAMPLER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define LRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define LRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants of the delayed linear resampler.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int CURVE_DEPTH_DEF = 1024;
    localparam int DATA_W          = 32;
    localparam int PROD_W          = 66;   // |dx| * |dy| < 2^66
    localparam int DIV_W           = 33;   // |dt| <= 2^32
    localparam int QUO_W           = 42;   // quotient held at 2^41
    localparam logic [QUO_W-1:0] QSAT = {1'b1, {(QUO_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_REWIND = 2'd3
    } mode_t;

    typedef struct packed {
        logic append;
        logic clear;
        logic rewind;
        logic q_start;
        logic walk_step;
        logic walk_stop;
        logic rd_lo;
        logic setup;
        logic mul0;
        logic mul1;
        logic div_start;
        logic out_load;
    } lrs_cmd_t;

    typedef struct packed {
        logic short_curve;
        logic walk_more;
        logic div_done;
        logic out_free;
    } lrs_status_t;

endpackage

/* sv/lrs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_div
// Restoring divider, one quotient bit per cycle, rounded and held at 2^41.
// ----------------------------------------------------------------------------
module lrs_div
    import lrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              busy,
    output logic [QUO_W-1:0]  quotient
);
    localparam int CNT_W = $clog2(PROD_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              sat_reg, sat_next;
    logic [DIV_W:0]    rem_sh;
    logic [DIV_W+1:0]  rem_dbl;
    logic [QUO_W:0]    quo_rnd;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        sat_next  = sat_reg;
        rem_sh    = {rem_reg, num_reg[PROD_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(PROD_W - 1);
            num_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
            sat_next  = 1'b0;
        end else if (busy_reg) begin
            // sticky overflow, checked before the shift
            if (quo_reg >= QSAT) sat_next = 1'b1;
            quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, divisor}) begin
                rem_next    = DIV_W'(rem_sh - {1'b0, divisor});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = rem_sh[DIV_W-1:0];
            end
            num_next = {num_reg[PROD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    // round half away from zero on the magnitude
    assign rem_dbl = {1'b0, rem_reg, 1'b0};
    assign quo_rnd = {1'b0, quo_reg} + ((rem_dbl >= (DIV_W+2)'(divisor)) ? 1'b1 : 1'b0);
    assign quotient = (sat_reg || quo_rnd > {1'b0, QSAT}) ? QSAT : quo_rnd[QUO_W-1:0];
    assign busy = busy_reg;

endmodule

/* sv/lrs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_datapath
// Curve memories, segment pointer, multiply and divide lanes, output register.
// ----------------------------------------------------------------------------
module lrs_datapath
    import lrs_pkg::*;
#(
    parameter int CURVE_DEPTH = CURVE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [31:0]   cfg_wr_data,
    input  logic [127:0]  s_tdata,
    input  lrs_cmd_t      cmd,
    output lrs_status_t   status,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [63:0]   m_tdata,
    output logic [0:0]    m_tuser
);
    localparam int AW = (CURVE_DEPTH > 1) ? $clog2(CURVE_DEPTH) : 1;
    localparam int CW = $clog2(CURVE_DEPTH + 1);

    logic [DATA_W-1:0] time_mem   [CURVE_DEPTH];
    logic [DATA_W-1:0] signal_mem [CURVE_DEPTH];
    logic [DATA_W-1:0] error_mem  [CURVE_DEPTH];
    logic [DATA_W-1:0] rd_time, rd_sig, rd_err;
    logic [AW-1:0]     rd_addr;

    logic [31:0]       delay_reg;
    logic [CW-1:0]     count_reg;
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     j_reg, j_next;
    logic [CW-1:0]     last;
    logic signed [32:0] t_reg;
    logic              short_reg;
    logic              end_reg;
    logic [DATA_W-1:0] t1_reg, s1_reg, e1_reg;

    logic [33:0]       a_reg;
    logic [DIV_W-1:0]  bs_reg, be_reg, d_reg;
    logic              negs_reg, nege_reg, dzero_reg;
    logic [DATA_W-1:0] bases_reg, basee_reg;
    logic [PROD_W-1:0] ps_reg, pe_reg;
    logic [16:0]       mul_a;
    logic [49:0]       m_s, m_e;

    logic [QUO_W-1:0]  q_s, q_e;
    logic              busy_s, busy_e;

    logic              m_tvalid_reg;
    logic [DATA_W-1:0] out_sig_reg, out_err_reg;
    logic              past_end_reg;

    logic signed [32:0] rd_time_x;
    logic signed [33:0] dx;
    logic signed [32:0] dt, dys, dye;

    assign last      = count_reg - 1'b1;
    assign rd_time_x = $signed({rd_time[31], rd_time});
    assign rd_addr   = cmd.rd_lo ? j_reg - 1'b1 : j_reg;

    // ---- curve memories
    always_ff @(posedge aclk) begin
        if (cmd.append && count_reg < CW'(CURVE_DEPTH)) begin
            time_mem[count_reg[AW-1:0]]   <= s_tdata[31:0];
            signal_mem[count_reg[AW-1:0]] <= s_tdata[63:32];
            error_mem[count_reg[AW-1:0]]  <= s_tdata[95:64];
        end
        rd_time <= time_mem[rd_addr];
        rd_sig  <= signal_mem[rd_addr];
        rd_err  <= error_mem[rd_addr];
    end

    // ---- pointer clamp at query start, increment on each walk step
    always_comb begin
        j_next = j_reg;
        if (cmd.q_start) begin
            if (ptr_reg == '0) begin
                j_next = AW'(1);
            end else if (CW'(ptr_reg) > last) begin
                j_next = last[AW-1:0];
            end else begin
                j_next = ptr_reg;
            end
        end else if (cmd.walk_step) begin
            j_next = j_reg + 1'b1;
        end
    end

    // ---- control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= '0;
            count_reg    <= '0;
            ptr_reg      <= AW'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) delay_reg <= cfg_wr_data;
            if (cmd.append && count_reg < CW'(CURVE_DEPTH)) count_reg <= count_reg + 1'b1;
            if (cmd.clear) begin
                count_reg <= '0;
                ptr_reg   <= AW'(1);
            end
            if (cmd.rewind) ptr_reg <= AW'(1);
            if (cmd.walk_stop) ptr_reg <= j_reg;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---- segment setup
    assign dx  = {t_reg[32], t_reg} - {{2{rd_time[31]}}, rd_time};
    assign dt  = $signed({t1_reg[31], t1_reg}) - rd_time_x;
    assign dys = $signed({s1_reg[31], s1_reg}) - $signed({rd_sig[31], rd_sig});
    assign dye = $signed({e1_reg[31], e1_reg}) - $signed({rd_err[31], rd_err});

    assign mul_a = cmd.mul1 ? a_reg[33:17] : a_reg[16:0];
    assign m_s   = mul_a * bs_reg;
    assign m_e   = mul_a * be_reg;

    always_ff @(posedge aclk) begin
        j_reg <= j_next;
        if (cmd.q_start) begin
            t_reg     <= $signed({s_tdata[127], s_tdata[127:96]})
                         + $signed({delay_reg[31], delay_reg});
            short_reg <= count_reg < CW'(2);
        end
        if (cmd.walk_stop) begin
            t1_reg  <= rd_time;
            s1_reg  <= rd_sig;
            e1_reg  <= rd_err;
            end_reg <= rd_time_x <= t_reg;
        end
        if (cmd.setup) begin
            a_reg     <= dx[33] ? 34'(-dx) : 34'(dx);
            bs_reg    <= dys[32] ? 33'(-dys) : 33'(dys);
            be_reg    <= dye[32] ? 33'(-dye) : 33'(dye);
            d_reg     <= dt[32] ? 33'(-dt) : 33'(dt);
            negs_reg  <= dx[33] ^ dys[32] ^ dt[32];
            nege_reg  <= dx[33] ^ dye[32] ^ dt[32];
            dzero_reg <= dt == '0;
            bases_reg <= rd_sig;
            basee_reg <= rd_err;
        end
        if (cmd.mul0) begin
            ps_reg <= PROD_W'(m_s);
            pe_reg <= PROD_W'(m_e);
        end
        if (cmd.mul1) begin
            ps_reg <= ps_reg + {m_s[48:0], 17'b0};
            pe_reg <= pe_reg + {m_e[48:0], 17'b0};
        end
    end

    lrs_div u_div_sig (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (ps_reg),
        .divisor  (d_reg),
        .busy     (busy_s),
        .quotient (q_s)
    );

    lrs_div u_div_err (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (pe_reg),
        .divisor  (d_reg),
        .busy     (busy_e),
        .quotient (q_e)
    );

    // base +/- quotient, saturated to 32 bits
    function automatic logic [DATA_W-1:0] combine(input logic [DATA_W-1:0] base,
                                                  input logic [QUO_W-1:0] q,
                                                  input logic neg);
        logic signed [QUO_W+1:0] bx;
        logic signed [QUO_W+1:0] qx;
        logic signed [QUO_W+1:0] r;
        bx = (QUO_W+2)'($signed(base));
        qx = $signed({2'b00, q});
        r  = neg ? bx - qx : bx + qx;
        if (r > (QUO_W+2)'(32'sh7fff_ffff)) begin
            combine = 32'h7fff_ffff;
        end else if (r < (QUO_W+2)'(-33'sh8000_0000)) begin
            combine = 32'h8000_0000;
        end else begin
            combine = r[DATA_W-1:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (short_reg) begin
                out_sig_reg  <= '0;
                out_err_reg  <= '0;
                past_end_reg <= 1'b1;
            end else if (dzero_reg) begin
                out_sig_reg  <= bases_reg;
                out_err_reg  <= basee_reg;
                past_end_reg <= end_reg;
            end else begin
                out_sig_reg  <= combine(bases_reg, q_s, negs_reg);
                out_err_reg  <= combine(basee_reg, q_e, nege_reg);
                past_end_reg <= end_reg;
            end
        end
    end

    assign status.short_curve = count_reg < CW'(2);
    assign status.walk_more   = (CW'(j_reg) < last) && (rd_time_x <= t_reg);
    assign status.div_done    = !(busy_s || busy_e);
    assign status.out_free    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_err_reg, out_sig_reg};
    assign m_tuser  = past_end_reg;

endmodule

/* sv/lrs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_ctrl
// Sequencer: decodes items, walks the segment, runs multiply and divide.
// ----------------------------------------------------------------------------
module lrs_ctrl
    import lrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  lrs_status_t status,
    output lrs_cmd_t    cmd
);
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_WRD    = 10'b00_0000_0010,
        ST_WCHK   = 10'b00_0000_0100,
        ST_RLO    = 10'b00_0000_1000,
        ST_SETUP  = 10'b00_0001_0000,
        ST_MUL0   = 10'b00_0010_0000,
        ST_MUL1   = 10'b00_0100_0000,
        ST_DSTART = 10'b00_1000_0000,
        ST_DWAIT  = 10'b01_0000_0000,
        ST_OUTW   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    mode_t  mode;
    logic   accept;

    assign mode     = mode_t'(s_tuser);
    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (mode)
                        MODE_APPEND: cmd.append = 1'b1;
                        MODE_CLEAR:  cmd.clear  = 1'b1;
                        MODE_REWIND: cmd.rewind = 1'b1;
                        MODE_QUERY: begin
                            cmd.q_start = 1'b1;
                            state_next  = status.short_curve ? ST_OUTW : ST_WRD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WRD: state_next = ST_WCHK;
            ST_WCHK: begin
                if (status.walk_more) begin
                    cmd.walk_step = 1'b1;
                    state_next    = ST_WRD;
                end else begin
                    cmd.walk_stop = 1'b1;
                    state_next    = ST_RLO;
                end
            end
            ST_RLO: begin
                cmd.rd_lo  = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_MUL0;
            end
            ST_MUL0: begin
                cmd.mul0   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (status.div_done) state_next = ST_OUTW;
            end
            ST_OUTW: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/delayed_linear_resampler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delayed_linear_resampler_top
// Piecewise linear resampler of a stored curve at delayed query times.
// ----------------------------------------------------------------------------
// Input items arrive on s_*: tuser is the mode (append, query, clear, rewind),
// tdata carries the sample fields and the query time. Each query gives one
// result item on m_*: interpolated signal and error, with past_end on tuser.
// Append, clear and rewind give no item. In a query the pointer walks the
// segments, each walk step being one registered read of the time memory;
// the two 66-step restoring dividers then run signal and error in parallel.
// A query on a curve of fewer than two samples skips the walk and the
// dividers and goes straight to the output register.
// Results sit in an output register: the block takes new items while a
// result waits, and a query finishing behind a stalled receiver holds until
// the register frees. Reset clears the curve length, sets the pointer to one
// and the delay to zero; memory contents are not cleared. The user must write
// time_delay through cfg_wr_en / cfg_wr_data only while idle; not enforced.
// ----------------------------------------------------------------------------
`include "delayed_linear_resampler_top_defines.svh"

module delayed_linear_resampler_top
    import lrs_pkg::*;
#(
    parameter int CURVE_DEPTH = CURVE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sample_time, sample_signal, sample_error, query_time
    input  logic [127:0] s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_signal, out_error
    output logic [63:0]  m_tdata,
    // past_end
    output logic [0:0]   m_tuser
);
    lrs_cmd_t    cmd;
    lrs_status_t status;

    lrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    lrs_datapath #(
        .CURVE_DEPTH (CURVE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    `LRS_ASSERT_NOW(a_load_free, cmd.out_load, status.out_free, "result loaded over a pending item")
    `LRS_ASSERT_NEXT(a_load_valid, cmd.out_load, m_tvalid, "loaded result not presented")
    `LRS_ASSERT_NOW(a_step_ok, cmd.walk_step, status.walk_more, "pointer advanced past its stop")
    `LRS_ASSERT_NEXT(a_div_busy, cmd.div_start, !status.div_done, "divider did not start")

endmodule
